/* rtl/core/trtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtm_pkg
// Shared types, constants and helpers of the raw-to-temperature mean core.
// ----------------------------------------------------------------------------
package trtm_pkg;

	localparam int W          = 48;
	localparam int CNT_W      = 21;
	localparam int TEMP_W     = 19;
	localparam int MAX_PIXELS = 1048576;
	localparam int STEP_W     = 6;
	localparam int DEN_STEPS  = 4;
	localparam int QDIV_STEPS = 47;
	localparam int DIV_STEPS  = 64;
	localparam int SQR_STEPS  = 24;
	localparam int KELVIN_CENTI = 27315;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -19'sd27315;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 19'sd200000;
	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

	typedef enum logic [2:0] {
		REG_GAIN, REG_OFFSET, REG_R1, REG_R2, REG_B, REG_O, REG_F
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GAIN, ST_ADJ, ST_CHECK, ST_DEN, ST_QLD, ST_QDIV, ST_ARG,
		ST_NORM, ST_SQR, ST_LN, ST_TLD, ST_TDIV, ST_TEMP, ST_ACC, ST_MLD,
		ST_MDIV, ST_EMIT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_GAIN, OP_ADJ, OP_DEN, OP_QLD, OP_STEP, OP_ARG,
		OP_NORM, OP_MANT, OP_SQR, OP_LN, OP_TLD, OP_TEMP, OP_BAD, OP_ACC,
		OP_MLD, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic full;
		logic zero_div;
		logic arg_bad;
		logic norm_done;
		logic ln_zero;
		logic out_busy;
	} dp_stat_t;

	function automatic logic signed [65:0] sx66(input logic [W-1:0] v);
		sx66 = $signed({{18{v[W-1]}}, v});
	endfunction

	function automatic logic signed [W-1:0] sat48(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sh7FFFFFFFFFFF;
		lo = -66'sh800000000000;
		if (v > hi) sat48 = hi[W-1:0];
		else if (v < lo) sat48 = lo[W-1:0];
		else sat48 = v[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag48(input logic [W-1:0] v);
		mag48 = v[W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

/* rtl/core/thermal_raw_to_temperature_mean_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_raw_to_temperature_mean_core
// Raw thermal pixels to frame-mean temperature via inverse Planck relation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one word per pixel: raw_pixel and
//   last_in_frame. Output channel (out_valid/out_stall) gives one word per
//   frame: mean in 0.01 degC, pixel count and an invalid-pixel flag.
//   Registers are written through wr_en/wr_index/wr_data; the user must write
//   them only while idle, as the core does not enforce it. One pixel at a
//   time: in_stall is low only in the idle state. A valid pixel is dominated
//   by the shared 1-bit/cycle divider (47 steps for R1/(R2*d), 64 steps for
//   B/ln) plus 24 squaring steps and the normalize steps of the log unit.
//   A zero log skips the B/ln divide; a zero divisor or a non-positive log
//   argument ends the pixel early, and a pixel past the frame limit is dropped.
//   The last pixel adds the 64-step mean divide.
//   The mean sits in an output register; the next frame runs while it waits.
//   If the receiver stalls, a further mean waits inside the core and input
//   stalls until the register frees.
//   Reset clears accumulators and output valid and loads default constants.
// ----------------------------------------------------------------------------
module thermal_raw_to_temperature_mean_core
	import trtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [2:0]               wr_index,
	input  logic [W-1:0]             wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [15:0]              raw_pixel,
	input  logic                     last_in_frame,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] mean_temp_centi,
	output logic [CNT_W-1:0]         pixel_total,
	output logic                     any_invalid
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	trtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	trtm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.raw_pixel       (raw_pixel),
		.last_in_frame   (last_in_frame),
		.out_stall       (out_stall),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_valid),
		.mean_temp_centi (mean_temp_centi),
		.pixel_total     (pixel_total),
		.any_invalid     (any_invalid)
	);

`ifndef NO_ASSERTIONS
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("pixel accepted while previous one in flight");
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_total != '0 && pixel_total <= CNT_W'(MAX_PIXELS)))
		else $error("pixel_total out of range");
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mean_temp_centi >= TEMP_LOW && mean_temp_centi <= TEMP_HIGH))
		else $error("mean out of range");
`endif
endmodule

/* rtl/core/trtm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtm_div
// Shared restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module trtm_div (
	input  logic        clk,
	input  logic        load,
	input  logic        step,
	input  logic [95:0] rem_init,
	input  logic [63:0] dividend,
	input  logic [95:0] divisor,
	output logic [63:0] quotient
);
	logic [95:0] rem_q;
	logic [95:0] dvs_q;
	logic [63:0] dvd_q;
	logic [63:0] quo_q;
	logic [96:0] trial;
	logic [96:0] diff;
	logic        ge;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= ge ? diff[95:0] : trial[95:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end
endmodule

/* rtl/core/trtm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtm_dp
// Datapath: config registers, pixel conversion, frame accumulators, output.
// ----------------------------------------------------------------------------
module trtm_dp
	import trtm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [2:0]               wr_index,
	input  logic [W-1:0]             wr_data,
	input  logic [15:0]              raw_pixel,
	input  logic                     last_in_frame,
	input  logic                     out_stall,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	output logic                     out_valid,
	output logic signed [TEMP_W-1:0] mean_temp_centi,
	output logic [CNT_W-1:0]         pixel_total,
	output logic                     any_invalid
);
	logic signed [W-1:0] gain_q, off_q, r1_q, r2_q, b_q, o_q, f_q;

	logic [15:0]         raw_q;
	logic                last_q;
	logic                bad_q;
	logic signed [W-1:0] x_q, d_q, a_q;
	logic [95:0]         den_q;
	logic                over_q;
	logic [46:0]         norm_q;
	logic [5:0]          k_q;
	logic [30:0]         m_q;
	logic [23:0]         frac_q;
	logic [28:0]         pm_q;
	logic                lneg_q;
	logic signed [TEMP_W-1:0] t_q;

	logic signed [W-1:0]  sum_q;
	logic [CNT_W-1:0]     count_q;
	logic                 inv_q;
	logic                 out_valid_q;
	logic signed [TEMP_W-1:0] mean_q;
	logic [CNT_W-1:0]     total_q;
	logic                 oinv_q;

	// divider hookup
	logic        div_load;
	logic [95:0] div_rem;
	logic [63:0] div_dvd;
	logic [95:0] div_dvs;
	logic [63:0] quo;

	trtm_div u_div (
		.clk      (clk),
		.load     (div_load),
		.step     (cmd.op == OP_STEP),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quo)
	);

	// combinational helpers
	logic signed [64:0]  gprod;
	logic signed [W-1:0] x1, dnext;
	logic [W-1:0]        r1m, r2m, dm, bm;
	logic [23:0]         ap, bp;
	logic [47:0]         pp;
	logic [95:0]         term;
	logic [46:0]         qm;
	logic signed [W-1:0] qs, anext;
	logic [61:0]         sq;
	logic [31:0]         s;
	logic signed [6:0]   kk;
	logic signed [30:0]  lg;
	logic [30:0]         lgm;
	logic [60:0]         lnp;
	logic [54:0]         nm;
	logic [CNT_W-1:0]    cdiv;
	logic [63:0]         tm;
	logic signed [TEMP_W-1:0] tnext;
	logic [W-1:0]        qmean;

	always_comb begin
		gprod = $signed({1'b0, raw_q}) * gain_q;
		x1    = sat48(sx66(x_q) - sx66(off_q));
		dnext = sat48(sx66(x1) + sx66(o_q));
		r1m   = mag48(r1_q);
		r2m   = mag48(r2_q);
		dm    = mag48(d_q);
		bm    = mag48(b_q);
		ap    = cmd.idx[1] ? r2m[47:24] : r2m[23:0];
		bp    = cmd.idx[0] ? dm[47:24] : dm[23:0];
		pp    = ap * bp;
		case (cmd.idx)
			2'd0:    term = {48'b0, pp};
			2'd3:    term = {pp, 48'b0};
			default: term = {24'b0, pp, 24'b0};
		endcase
		qm    = over_q ? 47'h7FFFFFFFFFFF : quo[46:0];
		qs    = (r1_q[W-1] ^ r2_q[W-1] ^ d_q[W-1]) ? -$signed({1'b0, qm})
			: $signed({1'b0, qm});
		anext = sat48(sx66(qs) + sx66(f_q));
		sq    = m_q * m_q;
		s     = sq[61:30];
		kk    = $signed({1'b0, k_q}) - 7'sd24;
		lg    = $signed({kk, 24'b0}) + $signed({7'b0, frac_q});
		lgm   = lg[30] ? 31'(-lg) : 31'(lg);
		lnp   = lgm[28:0] * LN2_Q32 + 61'h80000000;
		nm    = bm * 7'd100;
		cdiv  = (count_q == '0) ? CNT_W'(1) : count_q;
		tm    = quo;
		if (pm_q == '0) begin
			tnext = (!b_q[W-1] && b_q != '0) ? TEMP_HIGH : TEMP_LOW;
		end else if (b_q[W-1] ^ lneg_q) begin
			tnext = TEMP_LOW;
		end else if (tm > 64'(KELVIN_CENTI + 200000)) begin
			tnext = TEMP_HIGH;
		end else begin
			tnext = TEMP_W'(tm - 64'(KELVIN_CENTI));
		end
		qmean = sum_q[W-1] ? (~quo[W-1:0] + 1'b1) : quo[W-1:0];

		div_load = 1'b0;
		div_rem  = '0;
		div_dvd  = '0;
		div_dvs  = '0;
		case (cmd.op)
			OP_QLD: begin
				div_load = 1'b1;
				div_rem  = {47'b0, r1m, 1'b0};
				div_dvs  = den_q;
			end
			OP_TLD: begin
				div_load = 1'b1;
				div_dvd  = {9'b0, nm} + {36'b0, pm_q[28:1]};
				div_dvs  = {67'b0, pm_q};
			end
			OP_MLD: begin
				div_load = 1'b1;
				div_dvd  = {16'b0, mag48(sum_q)} + {44'b0, cdiv[CNT_W-1:1]};
				div_dvs  = {75'b0, cdiv};
			end
			default: ;
		endcase
	end

	assign stat.last      = last_q;
	assign stat.full      = count_q >= CNT_W'(MAX_PIXELS);
	assign stat.zero_div  = (r2_q == '0) || (d_q == '0);
	assign stat.arg_bad   = a_q[W-1] || (a_q == '0);
	assign stat.norm_done = norm_q[46];
	assign stat.ln_zero   = pm_q == '0;
	assign stat.out_busy  = out_valid_q && out_stall;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 48'sd16777216;
			off_q  <= '0;
			r1_q   <= '0;
			r2_q   <= 48'sd16777216;
			b_q    <= '0;
			o_q    <= '0;
			f_q    <= 48'sd16777216;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_GAIN:   gain_q <= wr_data;
				REG_OFFSET: off_q  <= wr_data;
				REG_R1:     r1_q   <= wr_data;
				REG_R2:     r2_q   <= wr_data;
				REG_B:      b_q    <= wr_data;
				REG_O:      o_q    <= wr_data;
				REG_F:      f_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// per-pixel working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				raw_q  <= raw_pixel;
				last_q <= last_in_frame;
				bad_q  <= 1'b0;
			end
			OP_GAIN: x_q <= sat48({gprod[64], gprod});
			OP_ADJ:  d_q <= dnext;
			OP_DEN:  den_q <= (cmd.idx == 2'd0) ? term : den_q + term;
			OP_QLD:  over_q <= {48'b0, r1m, 1'b0} >= {1'b0, den_q};
			OP_ARG: begin
				a_q    <= anext;
				norm_q <= anext[46:0];
				k_q    <= 6'd46;
			end
			OP_NORM: begin
				if (norm_q[46:39] == '0) begin
					norm_q <= {norm_q[38:0], 8'b0};
					k_q    <= k_q - 6'd8;
				end else begin
					norm_q <= {norm_q[45:0], 1'b0};
					k_q    <= k_q - 6'd1;
				end
			end
			OP_MANT: begin
				m_q    <= norm_q[46:16];
				frac_q <= '0;
			end
			OP_SQR: begin
				m_q    <= s[31] ? s[31:1] : s[30:0];
				frac_q <= {frac_q[22:0], s[31]};
			end
			OP_LN: begin
				pm_q   <= lnp[60:32];
				lneg_q <= lg[30];
			end
			OP_TEMP: t_q <= tnext;
			OP_BAD: begin
				t_q   <= TEMP_LOW;
				bad_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// frame accumulators and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			inv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ACC) begin
				sum_q   <= sum_q + W'(t_q);
				count_q <= count_q + 1'b1;
				inv_q   <= inv_q | bad_q;
			end else if (cmd.op == OP_EMIT) begin
				sum_q   <= '0;
				count_q <= '0;
				inv_q   <= 1'b0;
			end
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			mean_q  <= qmean[TEMP_W-1:0];
			total_q <= count_q;
			oinv_q  <= inv_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mean_temp_centi = mean_q;
	assign pixel_total     = total_q;
	assign any_invalid     = oinv_q;
endmodule

/* rtl/core/trtm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trtm_ctrl
// Sequencer: steps the datapath through one pixel and the frame mean.
// ----------------------------------------------------------------------------
module trtm_ctrl
	import trtm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	ctrl_state_t state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q + 1'b1;
		cmd.op   = OP_NONE;
		cmd.idx  = cnt_q[1:0];
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				if (stat.full) state_d = stat.last ? ST_MLD : ST_IDLE;
				else begin
					cmd.op  = OP_GAIN;
					state_d = ST_ADJ;
				end
			end
			ST_ADJ: begin
				cmd.op  = OP_ADJ;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cnt_d = '0;
				if (stat.zero_div) begin
					cmd.op  = OP_BAD;
					state_d = ST_ACC;
				end else state_d = ST_DEN;
			end
			ST_DEN: begin
				cmd.op = OP_DEN;
				if (cnt_q == STEP_W'(DEN_STEPS - 1)) state_d = ST_QLD;
			end
			ST_QLD: begin
				cmd.op  = OP_QLD;
				cnt_d   = '0;
				state_d = ST_QDIV;
			end
			ST_QDIV: begin
				cmd.op = OP_STEP;
				if (cnt_q == STEP_W'(QDIV_STEPS - 1)) state_d = ST_ARG;
			end
			ST_ARG: begin
				cmd.op  = OP_ARG;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				cnt_d = '0;
				if (stat.arg_bad) begin
					cmd.op  = OP_BAD;
					state_d = ST_ACC;
				end else if (stat.norm_done) begin
					cmd.op  = OP_MANT;
					state_d = ST_SQR;
				end else cmd.op = OP_NORM;
			end
			ST_SQR: begin
				cmd.op = OP_SQR;
				if (cnt_q == STEP_W'(SQR_STEPS - 1)) state_d = ST_LN;
			end
			ST_LN: begin
				cmd.op  = OP_LN;
				state_d = ST_TLD;
			end
			ST_TLD: begin
				cnt_d = '0;
				if (stat.ln_zero) state_d = ST_TEMP;
				else begin
					cmd.op  = OP_TLD;
					state_d = ST_TDIV;
				end
			end
			ST_TDIV: begin
				cmd.op = OP_STEP;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_TEMP;
			end
			ST_TEMP: begin
				cmd.op  = OP_TEMP;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = stat.last ? ST_MLD : ST_IDLE;
			end
			ST_MLD: begin
				cmd.op  = OP_MLD;
				cnt_d   = '0;
				state_d = ST_MDIV;
			end
			ST_MDIV: begin
				cmd.op = OP_STEP;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the mean until the output register can take it
				if (!stat.out_busy) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* tb/tb_thermal_raw_to_temperature_mean_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_raw_to_temperature_mean_core
// Self-checking bench for the raw-to-temperature frame-mean core.
// A queue of pixel words feeds a clocked driver, and a clocked monitor checks
// each frame mean against an inline fixed-point Planck predictor. Coefficient
// sets (defaults, camera-like, degenerate, extremes, random) are loaded
// between frames while the core is idle. Both channels idle in random bursts,
// and the final stretch runs without any idling.
// ----------------------------------------------------------------------------
module tb_thermal_raw_to_temperature_mean_core;
	import trtm_pkg::*;

	localparam logic [2:0] IDX_UNUSED = 3'd7;
	localparam logic [63:0] LN2_FRAC = 64'hB17217F8;
	localparam logic signed [127:0] LIM_HI = 128'sh7FFFFFFFFFFF;
	localparam logic signed [127:0] LIM_LO = -128'sh800000000000;
	localparam logic signed [47:0] ONE_Q24 = 48'sd16777216;
	localparam logic signed [47:0] CAM_R1 = 48'sd354112839352;
	localparam logic signed [47:0] CAM_R2 = 48'sd209715;
	localparam logic signed [47:0] CAM_B = 48'sd25182601216;
	localparam logic signed [47:0] CAM_O = -48'sd123144765440;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [15:0] raw;
		logic        last;
	} pixel_t;

	typedef struct {
		logic signed [TEMP_W-1:0] mean;
		logic [CNT_W-1:0]         total;
		logic                     inv;
	} frame_stat_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [W-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic [15:0] raw_pixel;
	logic last_in_frame;
	logic out_valid;
	logic out_stall;
	logic signed [TEMP_W-1:0] mean_temp_centi;
	logic [CNT_W-1:0] pixel_total;
	logic any_invalid;

	thermal_raw_to_temperature_mean_core dut (.*);

	pixel_t pixel_q[$];
	frame_stat_t frame_q[$];
	logic signed [W-1:0] coef [0:6];
	logic signed [63:0] centi_sum;
	int unsigned pix_count;
	logic bad_seen;
	int errors;
	int cycles;
	int gap_left;
	int stall_left;
	bit taken;
	bit calm;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [127:0] clip48(input logic signed [127:0] v);
		if (v > LIM_HI) return LIM_HI;
		if (v < LIM_LO) return LIM_LO;
		return v;
	endfunction

	function automatic logic [127:0] abs128(input logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	// log2 by repeated squaring of a Q1.30 mantissa, scaled by ln2
	function automatic logic signed [63:0] natural_log(input logic [47:0] a);
		int k;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] lgm;
		logic [63:0] pm;
		logic signed [63:0] kk;
		logic signed [63:0] lg;
		k = 0;
		frac = 0;
		while ((a >> k) > 1) k++;
		m = (k >= 30) ? (64'(a) >> (k - 30)) : (64'(a) << (30 - k));
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h80000000) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		kk = k - 24;
		lg = kk * 64'sd16777216 + $signed(frac);
		lgm = lg < 0 ? -lg : lg;
		pm = (lgm * LN2_FRAC + 64'h80000000) >> 32;
		return lg < 0 ? -$signed(pm) : $signed(pm);
	endfunction

	function automatic logic signed [63:0] pixel_centi(input logic [15:0] raw,
			output logic bad);
		logic signed [127:0] x, d, q, a, lnv, t, b;
		logic [127:0] qm, nm, dm, tm;
		bad = 1'b0;
		b = coef[REG_B];
		x = clip48($signed({112'd0, raw}) * 128'(coef[REG_GAIN]));
		x = clip48(x - 128'(coef[REG_OFFSET]));
		d = clip48(x + 128'(coef[REG_O]));
		if (coef[REG_R2] == 0 || d == 0) begin
			bad = 1'b1;
			return TEMP_LOW;
		end
		qm = (abs128(128'(coef[REG_R1])) << 48) / (abs128(128'(coef[REG_R2])) * abs128(d));
		if (qm > LIM_HI) qm = LIM_HI;
		q = ((coef[REG_R1] < 0) ^ (coef[REG_R2] < 0) ^ (d < 0)) ? -$signed(qm) : $signed(qm);
		a = clip48(q + 128'(coef[REG_F]));
		if (a <= 0) begin
			bad = 1'b1;
			return TEMP_LOW;
		end
		lnv = natural_log(a[47:0]);
		if (lnv == 0) return b > 0 ? TEMP_HIGH : TEMP_LOW;
		nm = abs128(b) * 100;
		dm = abs128(lnv);
		tm = (nm + dm / 2) / dm;
		t = ((b < 0) ^ (lnv < 0)) ? -$signed(tm) : $signed(tm);
		t = t - KELVIN_CENTI;
		if (t < TEMP_LOW) t = TEMP_LOW;
		if (t > TEMP_HIGH) t = TEMP_HIGH;
		return 64'(t);
	endfunction

	task automatic accumulate_pixel(input logic [15:0] raw, input logic last);
		logic bad;
		logic signed [63:0] t;
		logic [63:0] cnt, sm, mm;
		frame_stat_t fs;
		if (pix_count < MAX_PIXELS) begin
			t = pixel_centi(raw, bad);
			centi_sum += t;
			pix_count++;
			if (bad) bad_seen = 1'b1;
		end
		if (last) begin
			cnt = pix_count ? 64'(pix_count) : 64'd1;
			sm = centi_sum < 0 ? -centi_sum : centi_sum;
			mm = (sm + cnt / 2) / cnt;
			fs.mean = TEMP_W'(centi_sum < 0 ? -$signed(mm) : $signed(mm));
			fs.total = CNT_W'(pix_count);
			fs.inv = bad_seen;
			frame_q.push_back(fs);
			centi_sum = 0;
			pix_count = 0;
			bad_seen = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL thermal_raw_to_temperature_mean_core");
			$finish;
		end else if (arst_n) begin
			if (cycles % 300 == 0) quiet = ($urandom_range(0, 3) == 0);
			if (in_valid && !in_stall) begin
				accumulate_pixel(raw_pixel, last_in_frame);
				taken = 1;
			end
			if (out_valid && !out_stall) begin
				if (frame_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word: mean %0d total %0d inv %0b",
						mean_temp_centi, pixel_total, any_invalid);
				end else begin
					frame_stat_t e;
					e = frame_q.pop_front();
					if (mean_temp_centi !== e.mean || pixel_total !== e.total ||
							any_invalid !== e.inv) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp mean %0d total %0d inv %0b, got %0d %0d %0b",
								e.mean, e.total, e.inv, mean_temp_centi, pixel_total,
								any_invalid);
					end
				end
			end
		end
	end

	// pixel driver
	always @(negedge clk) begin
		pixel_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !taken)) begin
			taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else begin
					p = pixel_q.pop_front();
					raw_pixel <= p.raw;
					last_in_frame <= p.last;
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && !quiet && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [W-1:0] val);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		if (idx <= REG_F) coef[idx] = val;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic push_pixel(input logic [15:0] raw, input logic last);
		pixel_t p;
		p.raw = raw;
		p.last = last;
		pixel_q.push_back(p);
	endtask

	// frames of random length; mostly short, a few long
	task automatic push_frames(input int n);
		int len;
		logic [15:0] raw;
		while (n > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			if (len > n) len = n;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0: raw = 16'h0000;
					1: raw = 16'hFFFF;
					2: raw = 16'($urandom_range(7000, 7700));
					default: raw = 16'($urandom_range(0, 65535));
				endcase
				push_pixel(raw, i == len - 1);
			end
			n -= len;
		end
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || frame_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return LIM_HI[W-1:0];
			1: return LIM_LO[W-1:0];
			2: return '0;
			3: return ONE_Q24 * $signed(48'($urandom_range(0, 40)) - 48'sd20);
			4: return 48'($urandom_range(0, 1 << 20)) << $urandom_range(0, 30);
			default: return W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic load_camera();
		write_reg(REG_GAIN, ONE_Q24);
		write_reg(REG_OFFSET, '0);
		write_reg(REG_R1, CAM_R1);
		write_reg(REG_R2, CAM_R2);
		write_reg(REG_B, CAM_B);
		write_reg(REG_O, CAM_O);
		write_reg(REG_F, ONE_Q24);
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		raw_pixel = '0;
		last_in_frame = 1'b0;
		out_stall = 1'b0;
		errors = 0;
		cycles = 0;
		gap_left = 0;
		stall_left = 0;
		calm = 0;
		quiet = 0;
		centi_sum = 0;
		pix_count = 0;
		bad_seen = 1'b0;
		coef[REG_GAIN] = ONE_Q24;
		coef[REG_OFFSET] = '0;
		coef[REG_R1] = '0;
		coef[REG_R2] = ONE_Q24;
		coef[REG_B] = '0;
		coef[REG_O] = '0;
		coef[REG_F] = ONE_Q24;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: log of one, zero B
		push_pixel(16'h0000, 1'b1);
		push_pixel(16'hFFFF, 1'b0);
		push_pixel(16'h0001, 1'b1);
		drain();

		// camera-like set with directed edges: negative argument, zero divisor
		load_camera();
		write_reg(IDX_UNUSED, W'({$urandom, $urandom}));
		push_pixel(16'h0000, 1'b1);
		push_pixel(16'd7340, 1'b1);
		push_pixel(16'hFFFF, 1'b1);
		push_pixel(16'd7341, 1'b0);
		push_pixel(16'd20000, 1'b0);
		push_pixel(16'd0, 1'b1);
		push_frames(500);
		drain();

		// log exactly zero with positive B, then zero R2
		write_reg(REG_R1, '0);
		push_pixel(16'd9000, 1'b0);
		push_pixel(16'hFFFF, 1'b1);
		drain();
		load_camera();
		write_reg(REG_R2, '0);
		push_pixel(16'd12000, 1'b1);
		push_pixel(16'd30000, 1'b0);
		push_pixel(16'd30001, 1'b1);
		drain();

		// all extremes
		write_reg(REG_GAIN, LIM_HI[W-1:0]);
		write_reg(REG_OFFSET, LIM_LO[W-1:0]);
		write_reg(REG_R1, LIM_HI[W-1:0]);
		write_reg(REG_R2, 48'd1);
		write_reg(REG_B, LIM_LO[W-1:0]);
		write_reg(REG_O, LIM_LO[W-1:0]);
		write_reg(REG_F, LIM_LO[W-1:0]);
		push_frames(20);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r <= REG_F; r++) write_reg(r[2:0], pick_coef());
			if (ph % 2 == 0) write_reg(REG_R2, CAM_R2);
			push_frames(100);
			drain();
		end

		// final stretch without idling
		load_camera();
		calm = 1;
		push_frames(500);
		drain();

		if (errors == 0) begin
			$display("PASS thermal_raw_to_temperature_mean_core");
		end else begin
			$display("FAIL thermal_raw_to_temperature_mean_core");
		end
		$finish;
	end

endmodule
